### rtl/frac_pkg.sv
// types, constants and command/status words shared by the fraction reducer
`timescale 1ns / 1ps
`default_nettype none
package frac_pkg;

  localparam int WIDTH = 31;
  localparam int CNT_W = $clog2(WIDTH + 1);

  typedef struct packed {
    logic [WIDTH-1:0] numerator;
    logic [WIDTH-1:0] denominator;
  } frac_in_t;

  typedef struct packed {
    logic [WIDTH-1:0] reduced_numerator;
    logic [WIDTH-1:0] reduced_denominator;
    logic [WIDTH-1:0] common_divisor;
    logic             zero_denominator;
  } frac_out_t;

  typedef enum logic [1:0] {
    DIV_EUC,
    DIV_NUM,
    DIV_DEN
  } div_sel_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_EUC,
    ST_EWAIT,
    ST_NWAIT,
    ST_DWAIT
  } state_t;

  typedef struct packed {
    logic     load;
    logic     div_go;
    div_sel_t div_sel;
    logic     euc_step;
    logic     save_rn;
    logic     emit;
    logic     emit_zero;
  } frac_cmd_t;

  typedef struct packed {
    logic den_zero;
    logic b_zero;
    logic div_busy;
  } frac_status_t;

endpackage
`default_nettype wire

### rtl/frac_dp.sv
// datapath: operand registers, bit-serial divider and result register
`timescale 1ns / 1ps
`default_nettype none
module frac_dp (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire frac_pkg::frac_in_t   operand,
  input  wire frac_pkg::frac_cmd_t  cmd,
  output frac_pkg::frac_status_t    status,
  output frac_pkg::frac_out_t       result,
  output logic                      done
);
  import frac_pkg::*;

  logic [WIDTH-1:0] num;
  logic [WIDTH-1:0] den;
  logic [WIDTH-1:0] a;
  logic [WIDTH-1:0] b;
  logic [WIDTH-1:0] rn;
  logic [WIDTH-1:0] dvd;
  logic [WIDTH-1:0] dvs;
  logic [WIDTH-1:0] rem;
  logic [CNT_W-1:0] cnt;
  logic             run;

  logic [WIDTH:0]   rem_sh;
  logic             ge;
  logic [WIDTH-1:0] go_dvd;

  assign rem_sh = {rem, dvd[WIDTH-1]};
  assign ge     = rem_sh >= {1'b0, dvs};

  always_comb begin
    unique case (cmd.div_sel)
      DIV_EUC: go_dvd = a;
      DIV_NUM: go_dvd = num;
      DIV_DEN: go_dvd = den;
      default: go_dvd = a;
    endcase
  end

  assign status.den_zero = (den == '0);
  assign status.b_zero   = (b == '0);
  assign status.div_busy = run;

  // operands
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      num <= operand.numerator;
      den <= operand.denominator;
      a   <= operand.numerator;
      b   <= operand.denominator;
    end else if (cmd.euc_step) begin
      a <= b;
      b <= rem;
    end
    if (cmd.save_rn) begin
      rn <= dvd;
    end
  end

  // restoring divider, one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      run <= 1'b0;
      cnt <= '0;
    end else if (cmd.div_go) begin
      run <= 1'b1;
      cnt <= CNT_W'(WIDTH);
    end else if (run) begin
      cnt <= cnt - 1'b1;
      if (cnt == CNT_W'(1)) begin
        run <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_go) begin
      dvd <= go_dvd;
      dvs <= (cmd.div_sel == DIV_EUC) ? b : a;
      rem <= '0;
    end else if (run) begin
      dvd <= {dvd[WIDTH-2:0], ge};
      rem <= ge ? WIDTH'(rem_sh - {1'b0, dvs}) : rem_sh[WIDTH-1:0];
    end
  end

  // result word
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      if (cmd.emit_zero) begin
        result <= '{reduced_numerator: '0, reduced_denominator: '0,
                    common_divisor: '0, zero_denominator: 1'b1};
      end else begin
        result <= '{reduced_numerator: rn, reduced_denominator: dvd,
                    common_divisor: a, zero_denominator: 1'b0};
      end
    end
  end

endmodule
`default_nettype wire

### rtl/frac_ctrl.sv
// controller state machine sequencing the euclid steps and final divisions
`timescale 1ns / 1ps
`default_nettype none
module frac_ctrl (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   start,
  input  wire frac_pkg::frac_status_t status,
  output frac_pkg::frac_cmd_t         cmd,
  output logic                        busy
);
  import frac_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (start) state_next = ST_CHECK;
      ST_CHECK: state_next = status.den_zero ? ST_IDLE : ST_EUC;
      ST_EUC:   state_next = status.b_zero ? ST_NWAIT : ST_EWAIT;
      ST_EWAIT: if (!status.div_busy) state_next = ST_EUC;
      ST_NWAIT: if (!status.div_busy) state_next = ST_DWAIT;
      ST_DWAIT: if (!status.div_busy) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd         = '0;
    cmd.div_sel = DIV_EUC;
    busy        = (state != ST_IDLE);
    unique case (state)
      ST_IDLE: begin
        cmd.load = start;
      end
      ST_CHECK: begin
        cmd.emit      = status.den_zero;
        cmd.emit_zero = status.den_zero;
      end
      ST_EUC: begin
        cmd.div_go  = 1'b1;
        cmd.div_sel = status.b_zero ? DIV_NUM : DIV_EUC;
      end
      ST_EWAIT: begin
        cmd.euc_step = !status.div_busy;
      end
      ST_NWAIT: begin
        cmd.save_rn = !status.div_busy;
        cmd.div_go  = !status.div_busy;
        cmd.div_sel = DIV_DEN;
      end
      ST_DWAIT: begin
        cmd.emit = !status.div_busy;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule
`default_nettype wire

### rtl/fraction_reducer_euclid.sv
// top level: fraction reduction by euclid's gcd with a shared serial divider
// a zero denominator needs no division; else the divider runs once per euclid
// remainder step, then for both quotients; one word in flight at a time
// the single bit-serial divider (one quotient bit a cycle) serves every division
// result shows for one cycle with done; the receiver cannot stall
// synchronous reset returns the controller to idle and clears done
`timescale 1ns / 1ps
`default_nettype none
module fraction_reducer_euclid (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  output logic                     busy,
  input  wire frac_pkg::frac_in_t  operand,
  output logic                     done,
  output frac_pkg::frac_out_t      result
);
  import frac_pkg::*;

  frac_cmd_t    cmd;
  frac_status_t status;

  frac_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  frac_dp u_dp (
    .clk     (clk),
    .rst     (rst),
    .operand (operand),
    .cmd     (cmd),
    .status  (status),
    .result  (result),
    .done    (done)
  );

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result word while busy");

  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("accepted word did not start work");

  a_gcd_nonzero: assert property (@(posedge clk) disable iff (rst)
    done && !result.zero_denominator |-> result.common_divisor != '0)
    else $error("zero divisor on valid fraction");

  a_zero_den: assert property (@(posedge clk) disable iff (rst)
    done && result.zero_denominator |->
      result.reduced_numerator == '0 && result.reduced_denominator == '0 &&
      result.common_divisor == '0)
    else $error("zero denominator result not cleared");

endmodule
`default_nettype wire

### bench/tb_fraction_reducer_euclid.sv
// self-checking testbench for fraction_reducer_euclid: directed rows, then random fractions
`timescale 1ns / 1ps
module tb_fraction_reducer_euclid;
  import frac_pkg::*;

  localparam int MAX_STEPS = 48;
  localparam int MAX_LATENCY = 2 + MAX_STEPS * (WIDTH + 2) + 2 * (WIDTH + 1);
  localparam int RANDOM_WORDS = 600;
  localparam int CYCLE_LIMIT = 4_000_000;
  localparam logic [WIDTH-1:0] VMAX = {WIDTH{1'b1}};

  typedef struct packed {
    frac_in_t  word;
    logic      known;
    frac_out_t want;
  } directed_row_t;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      start = 1'b0;
  frac_in_t  operand = '0;
  logic      busy;
  logic      done;
  frac_out_t result;

  frac_out_t     expected_reductions[$];
  directed_row_t directed_words[$];
  int            error_count = 0;
  int            cycle_count = 0;
  bit            burst_mode = 1'b0;

  fraction_reducer_euclid dut (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .operand (operand),
    .done    (done),
    .result  (result)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic frac_out_t reduce_fraction(input frac_in_t w);
    frac_out_t        r;
    logic [WIDTH-1:0] a;
    logic [WIDTH-1:0] b;
    logic [WIDTH-1:0] rem;
    r = '0;
    if (w.denominator == '0) begin
      r.zero_denominator = 1'b1;
      return r;
    end
    a = w.numerator;
    b = w.denominator;
    while (b != '0) begin
      rem = a % b;
      a = b;
      b = rem;
    end
    r.reduced_numerator = w.numerator / a;
    r.reduced_denominator = w.denominator / a;
    r.common_divisor = a;
    return r;
  endfunction

  function automatic logic [WIDTH-1:0] rand_field();
    logic [31:0] v;
    v = $urandom;
    return v[WIDTH-1:0];
  endfunction

  function automatic frac_in_t random_fraction();
    frac_in_t    w;
    int unsigned pick;
    int unsigned g;
    int unsigned k;
    int unsigned f0;
    int unsigned f1;
    int unsigned t;
    pick = $urandom_range(0, 99);
    w.numerator = rand_field();
    w.denominator = rand_field();
    if (pick < 10) begin
      w.numerator = WIDTH'($urandom_range(0, 1000));
      w.denominator = WIDTH'($urandom_range(0, 1000));
    end else if (pick < 30) begin
      // shared factor so the reduction is not trivial
      g = $urandom_range(1, 65535);
      w.numerator = WIDTH'($urandom_range(0, 32767) * g);
      w.denominator = WIDTH'($urandom_range(1, 32767) * g);
    end else if (pick < 35) begin
      w.denominator = '0;
    end else if (pick < 40) begin
      w.numerator = '0;
    end else if (pick < 45) begin
      // consecutive fibonacci numbers give the longest euclid chains
      k = $urandom_range(20, 45);
      f0 = 0;
      f1 = 1;
      repeat (k) begin
        t = f0 + f1;
        f0 = f1;
        f1 = t;
      end
      if ($urandom_range(0, 1) == 0) begin
        w.numerator = WIDTH'(f1);
        w.denominator = WIDTH'(f0);
      end else begin
        w.numerator = WIDTH'(f0);
        w.denominator = WIDTH'(f1);
      end
    end
    return w;
  endfunction

  function automatic int pick_gap();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (burst_mode || p < 55) return 0;
    if (p < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 50);
  endfunction

  task automatic add_row(input logic [WIDTH-1:0] num, input logic [WIDTH-1:0] den,
                         input logic known, input logic [WIDTH-1:0] rn,
                         input logic [WIDTH-1:0] rd, input logic [WIDTH-1:0] g,
                         input logic z);
    directed_row_t row;
    row.word.numerator = num;
    row.word.denominator = den;
    row.known = known;
    row.want.reduced_numerator = rn;
    row.want.reduced_denominator = rd;
    row.want.common_divisor = g;
    row.want.zero_denominator = z;
    directed_words.push_back(row);
  endtask

  task automatic send_word(input frac_in_t w, input frac_out_t want);
    start <= 1'b1;
    operand <= w;
    @(posedge clk);
    while (busy) @(posedge clk);
    expected_reductions.push_back(want);
  endtask

  task automatic idle_for(input int n);
    frac_in_t noise;
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) begin
        noise.numerator = rand_field();
        noise.denominator = rand_field();
        operand <= noise;
        @(posedge clk);
      end
    end
  endtask

  task automatic drain_results();
    start <= 1'b0;
    while (expected_reductions.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    frac_out_t want;
    if (!rst && done) begin
      if (expected_reductions.size() == 0) begin
        $error("unexpected result word: %h", result);
        error_count = error_count + 1;
      end else begin
        want = expected_reductions.pop_front();
        if (result.reduced_numerator !== want.reduced_numerator) begin
          $error("reduced_numerator: expected %0d, actual %0d",
                 want.reduced_numerator, result.reduced_numerator);
          error_count = error_count + 1;
        end
        if (result.reduced_denominator !== want.reduced_denominator) begin
          $error("reduced_denominator: expected %0d, actual %0d",
                 want.reduced_denominator, result.reduced_denominator);
          error_count = error_count + 1;
        end
        if (result.common_divisor !== want.common_divisor) begin
          $error("common_divisor: expected %0d, actual %0d",
                 want.common_divisor, result.common_divisor);
          error_count = error_count + 1;
        end
        if (result.zero_denominator !== want.zero_denominator) begin
          $error("zero_denominator: expected %0d, actual %0d",
                 want.zero_denominator, result.zero_denominator);
          error_count = error_count + 1;
        end
      end
    end
  end

  initial begin
    frac_in_t w;
    // zero denominator, zero numerator and extremes with results read off directly
    add_row(0, 0, 1, 0, 0, 0, 1);
    add_row(VMAX, 0, 1, 0, 0, 0, 1);
    add_row(31'h2AAAAAAA, 0, 1, 0, 0, 0, 1);
    add_row(0, 1, 1, 0, 1, 1, 0);
    add_row(0, VMAX, 1, 0, 1, VMAX, 0);
    add_row(1, 1, 1, 1, 1, 1, 0);
    add_row(VMAX, 1, 1, VMAX, 1, 1, 0);
    add_row(1, VMAX, 1, 1, VMAX, 1, 0);
    add_row(VMAX, VMAX, 1, 1, 1, VMAX, 0);
    // predicted rows
    add_row(1836311903, 1134903170, 0, 0, 0, 0, 0);
    add_row(1134903170, 1836311903, 0, 0, 0, 0, 0);
    add_row(31'h40000000, 31'h20000000, 0, 0, 0, 0, 0);
    add_row(31'h2AAAAAAA, 31'h55555555, 0, 0, 0, 0, 0);
    add_row(31'h55555555, 31'h2AAAAAAA, 0, 0, 0, 0, 0);
    add_row(12, 18, 0, 0, 0, 0, 0);
    add_row(6, 4, 0, 0, 0, 0, 0);
    add_row(VMAX - 1'b1, VMAX, 0, 0, 0, 0, 0);
    add_row(VMAX - 1'b1, 2, 0, 0, 0, 0, 0);
    add_row(31'h7FFF0000, 31'h0000FFFF, 0, 0, 0, 0, 0);

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_words[i]) begin
      if (directed_words[i].known)
        send_word(directed_words[i].word, directed_words[i].want);
      else
        send_word(directed_words[i].word, reduce_fraction(directed_words[i].word));
      idle_for(pick_gap());
    end
    drain_results();

    for (int n = 0; n < RANDOM_WORDS; n++) begin
      if (n % 40 == 0) burst_mode = ($urandom_range(0, 3) == 0);
      if (n == RANDOM_WORDS / 2) drain_results();
      w = random_fraction();
      send_word(w, reduce_fraction(w));
      idle_for(pick_gap());
    end

    drain_results();
    repeat (MAX_LATENCY) @(posedge clk);

    if (error_count == 0 && expected_reductions.size() == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule

### sim.f
rtl/frac_pkg.sv
rtl/frac_dp.sv
rtl/frac_ctrl.sv
rtl/fraction_reducer_euclid.sv
bench/tb_fraction_reducer_euclid.sv
